/* hdl/pibd_pkg.sv */
`timescale 1ns / 1ps
// Package for the pulse interval bit decoder: transaction payload types,
// configuration register set, command, class and register index codes.
// Depends on nothing.
package pibd_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int LATCH_BITS  = 40;
   localparam int FLAGS_W     = 4;

   localparam logic [1:0] KIND_START    = 2'd0;
   localparam logic [1:0] KIND_EDGE     = 2'd1;
   localparam logic [1:0] KIND_OVERFLOW = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_LOW    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_HIGH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_LOW     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_HIGH    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_LOW   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_HIGH  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ERROR_ABOVE = 3'd6;

   localparam logic [7:0] RESET_ZERO_LOW    = 8'd71;
   localparam logic [7:0] RESET_ZERO_HIGH   = 8'd81;
   localparam logic [7:0] RESET_ONE_LOW     = 8'd118;
   localparam logic [7:0] RESET_ONE_HIGH    = 8'd128;
   localparam logic [7:0] RESET_START_LOW   = 8'd130;
   localparam logic [7:0] RESET_START_HIGH  = 8'd140;
   localparam logic [7:0] RESET_ERROR_ABOVE = 8'd201;

   localparam logic [2:0] CLS_NONE  = 3'd0;
   localparam logic [2:0] CLS_ZERO  = 3'd1;
   localparam logic [2:0] CLS_ONE   = 3'd2;
   localparam logic [2:0] CLS_START = 3'd3;
   localparam logic [2:0] CLS_ERROR = 3'd4;

   localparam int ST_STARTED  = 0;
   localparam int ST_ERROR    = 1;
   localparam int ST_FINISHED = 2;
   localparam int ST_SUM_OK   = 3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] interval;
   } req_type;

   typedef struct packed {
      logic       listening;
      logic       started;
      logic       finished;
      logic       checksum_ok;
      logic       error;
      logic [5:0] bits_received;
      logic [7:0] humidity_int;
      logic [7:0] humidity_frac;
      logic [7:0] temp_int;
      logic [7:0] temp_frac;
      logic [7:0] check_byte;
   } rsp_type;

   typedef struct packed {
      logic [7:0] zero_low;
      logic [7:0] zero_high;
      logic [7:0] one_low;
      logic [7:0] one_high;
      logic [7:0] start_low;
      logic [7:0] start_high;
      logic [7:0] error_above;
   } cfg_type;

endpackage

/* hdl/pibd_csr.sv */
`timescale 1ns / 1ps
// Configuration registers of the pulse interval bit decoder: interval windows
// and the error threshold. Depends on pibd_pkg.
module pibd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pibd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [7:0]                        csr_wdata,
   output pibd_pkg::cfg_type                 cfg
);
   import pibd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ZERO_LOW:    cfg_in.zero_low    = csr_wdata;
            CSR_ZERO_HIGH:   cfg_in.zero_high   = csr_wdata;
            CSR_ONE_LOW:     cfg_in.one_low     = csr_wdata;
            CSR_ONE_HIGH:    cfg_in.one_high    = csr_wdata;
            CSR_START_LOW:   cfg_in.start_low   = csr_wdata;
            CSR_START_HIGH:  cfg_in.start_high  = csr_wdata;
            CSR_ERROR_ABOVE: cfg_in.error_above = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_low    <= RESET_ZERO_LOW;
         cfg_ff.zero_high   <= RESET_ZERO_HIGH;
         cfg_ff.one_low     <= RESET_ONE_LOW;
         cfg_ff.one_high    <= RESET_ONE_HIGH;
         cfg_ff.start_low   <= RESET_START_LOW;
         cfg_ff.start_high  <= RESET_START_HIGH;
         cfg_ff.error_above <= RESET_ERROR_ABOVE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hdl/pibd_classify.sv */
`timescale 1ns / 1ps
// Interval classifier: sorts one edge interval into zero, one, start mark,
// error or nothing by the configured windows. Depends on pibd_pkg.
module pibd_classify (
   input  logic [7:0]        interval,
   input  pibd_pkg::cfg_type cfg,
   output logic [2:0]        cls
);
   import pibd_pkg::*;

   logic in_zero;
   logic in_one;
   logic in_start;
   logic too_long;

   assign in_zero  = (interval >= cfg.zero_low) && (interval <= cfg.zero_high);
   assign in_one   = (interval >= cfg.one_low) && (interval <= cfg.one_high);
   assign in_start = (interval >= cfg.start_low) && (interval <= cfg.start_high);
   assign too_long = interval > cfg.error_above;

   // The zero window wins over the one window, which wins over the start mark.
   always_comb begin
      if (in_zero) begin
         cls = CLS_ZERO;
      end else if (in_one) begin
         cls = CLS_ONE;
      end else if (in_start) begin
         cls = CLS_START;
      end else if (too_long) begin
         cls = CLS_ERROR;
      end else begin
         cls = CLS_NONE;
      end
   end

endmodule

/* hdl/pulse_interval_bit_decoder.sv */
`timescale 1ns / 1ps
// Pipeline: an accepted transaction is held in the input register; the result
// register then loads from it when the state update advances.
// Throughput: one transaction per cycle unless the result output stalls, set by
// the input register feeding the single state update and result register stage.
// Reset: synchronous; clears the frame state and flags, stops listening and
// restores the window registers to their defaults.
// Top level of the pulse interval bit decoder. Depends on pibd_pkg,
// pibd_csr and pibd_classify.
module pulse_interval_bit_decoder #(
   parameter int FRAME_BITS = 40
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  pibd_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pibd_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pibd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [7:0]                        csr_wdata
);
   import pibd_pkg::*;

   localparam int CNT_W = $clog2(FRAME_BITS + 1);

   cfg_type                  cfg;
   logic [2:0]               cls;

   logic                     in_valid_ff;
   req_type                  in_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   rsp_type                  rsp_ff;
   rsp_type                  rsp_in;
   logic                     advance;

   logic                     active_ff;
   logic                     active_in;
   logic [FLAGS_W-1:0]       flags_ff;
   logic [FLAGS_W-1:0]       flags_in;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic [FRAME_BITS-1:0]    shift_ff;
   logic [FRAME_BITS-1:0]    shift_in;
   logic [LATCH_BITS-1:0]    latch_ff;
   logic [LATCH_BITS-1:0]    latch_in;

   logic [FRAME_BITS-1:0]    shift_next;
   logic [CNT_W-1:0]         count_next;
   logic [LATCH_BITS+FRAME_BITS-1:0] shift_wide;
   logic [LATCH_BITS-1:0]    latch_next;
   logic [7:0]               sum;

   pibd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pibd_classify u_classify (
      .interval (in_ff.interval),
      .cfg      (cfg),
      .cls      (cls)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign shift_next = {shift_ff[FRAME_BITS-2:0], (cls == CLS_ONE)};
   assign count_next = count_ff + 1'b1;
   assign shift_wide = {{LATCH_BITS{1'b0}}, shift_next};
   assign latch_next = shift_wide[LATCH_BITS-1:0];
   assign sum = latch_next[39:32] + latch_next[31:24] + latch_next[23:16]
              + latch_next[15:8];

   always_comb begin
      active_in = active_ff;
      flags_in  = flags_ff;
      count_in  = count_ff;
      shift_in  = shift_ff;
      latch_in  = latch_ff;
      case (in_ff.kind)
         KIND_START: begin
            active_in = 1'b1;
            flags_in  = '0;
            count_in  = '0;
            shift_in  = '0;
            latch_in  = '0;
         end
         KIND_EDGE: begin
            if (active_ff) begin
               case (cls)
                  CLS_ZERO, CLS_ONE: begin
                     count_in = count_next;
                     shift_in = shift_next;
                     if (count_next == CNT_W'(FRAME_BITS)) begin
                        active_in = 1'b0;
                        shift_in  = '0;
                        latch_in  = latch_next;
                        flags_in[ST_FINISHED] = 1'b1;
                        if (sum == latch_next[7:0]) begin
                           flags_in[ST_SUM_OK] = 1'b1;
                        end else begin
                           flags_in[ST_ERROR] = 1'b1;
                        end
                     end
                  end
                  CLS_START: begin
                     flags_in = '0;
                     flags_in[ST_STARTED] = 1'b1;
                  end
                  CLS_ERROR: begin
                     flags_in[ST_ERROR] = 1'b1;
                     active_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         KIND_OVERFLOW: begin
            if (active_ff) begin
               flags_in[ST_ERROR] = 1'b1;
               active_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_in.listening     = active_in;
      rsp_in.started       = flags_in[ST_STARTED];
      rsp_in.finished      = flags_in[ST_FINISHED];
      rsp_in.checksum_ok   = flags_in[ST_SUM_OK];
      rsp_in.error         = flags_in[ST_ERROR];
      rsp_in.bits_received = 6'(count_in);
      rsp_in.humidity_int  = latch_in[39:32];
      rsp_in.humidity_frac = latch_in[31:24];
      rsp_in.temp_int      = latch_in[23:16];
      rsp_in.temp_frac     = latch_in[15:8];
      rsp_in.check_byte    = latch_in[7:0];
   end

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         flags_ff     <= '0;
         count_ff     <= '0;
         shift_ff     <= '0;
         latch_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            active_ff <= active_in;
            flags_ff  <= flags_in;
            count_ff  <= count_in;
            shift_ff  <= shift_in;
            latch_ff  <= latch_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_listen_below_frame: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (count_ff < CNT_W'(FRAME_BITS)))
      else $error("Decoder is listening with a full frame count.");

   a_sumok_needs_finish: assert property (@(posedge clock) disable iff (reset)
      flags_ff[ST_SUM_OK] |-> flags_ff[ST_FINISHED] && !active_ff)
      else $error("Checksum flag is set without a finished frame.");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && in_ff.kind == KIND_START) |=>
         active_ff && count_ff == '0 && flags_ff == '0)
      else $error("Start transaction did not clear the frame state.");

   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("Processed transaction did not produce a result.");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff && $stable(in_ff))
      else $error("Pending input transaction was lost or changed.");
`endif

endmodule
